FILE: src/kscu_pkg.sv
// shared constants and helpers for the keyword substitution cipher unit
package kscu_pkg;

  localparam int NumLetters = 26;
  localparam int IdxW = 5;

  localparam logic [7:0] AsciiUpperA = 8'h41;
  localparam logic [7:0] AsciiUpperZ = 8'h5a;
  localparam logic [7:0] AsciiLowerA = 8'h61;
  localparam logic [7:0] AsciiLowerZ = 8'h7a;

  localparam logic [2:0] OpClear   = 3'd0;
  localparam logic [2:0] OpAddKey  = 3'd1;
  localparam logic [2:0] OpFinish  = 3'd2;
  localparam logic [2:0] OpEncrypt = 3'd3;
  localparam logic [2:0] OpDecrypt = 3'd4;

  typedef logic [IdxW-1:0] letter_idx_t;

  function automatic logic is_letter(input logic [7:0] ch);
    is_letter = (ch >= AsciiUpperA && ch <= AsciiUpperZ) ||
                (ch >= AsciiLowerA && ch <= AsciiLowerZ);
  endfunction

  function automatic letter_idx_t letter_index(input logic [7:0] ch);
    logic [7:0] diff;
    if (ch >= AsciiLowerA) begin
      diff = ch - AsciiLowerA;
    end else begin
      diff = ch - AsciiUpperA;
    end
    letter_index = diff[IdxW-1:0];
  endfunction

endpackage

FILE: src/keyword_substitution_cipher_unit.sv
// keyword substitution cipher unit: key building, table fill and lookup
//
//  channel | signals                     | word
//  --------+-----------------------------+---------------------------
//  in      | in_valid, in_ready          | opcode, in_char
//  out     | out_valid, out_ready        | out_char, error
//
// one word per cycle for clear, add, encrypt and decrypt unless the output
// stalls; a result passes the table read, then the output register
// finish holds in_ready low while the fill walks every letter
// reset clears the used-letter mask, key length and ready flag; the tables
// hold nothing valid until a key is built
// a stalled output holds one word in the read stage, then in_ready drops
module keyword_substitution_cipher_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] opcode,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       error
);
  import kscu_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StFill = 1'b1;

  logic state;
  logic [NumLetters-1:0] letters_used;
  logic [IdxW-1:0] key_length;
  logic key_ready;
  logic [IdxW-1:0] fill_idx;

  logic [IdxW-1:0] cipher_mem [NumLetters];
  logic [IdxW-1:0] inverse_mem [NumLetters];
  logic [IdxW-1:0] cipher_rd;
  logic [IdxW-1:0] inverse_rd;

  logic s1_valid;
  logic s1_use_mem;
  logic s1_inv;
  logic [7:0] s1_char;
  logic s1_err;

  logic accept;
  logic s1_advance;
  logic in_letter;
  letter_idx_t in_idx;

  logic wr_en;
  logic [IdxW-1:0] wr_letter;
  logic [7:0] res_char;
  logic res_err;
  logic res_use_mem;

  assign in_letter  = is_letter(in_char);
  assign in_idx     = letter_index(in_char);
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = (state == StIdle) && (!s1_valid || s1_advance);
  assign accept     = in_valid && in_ready;

  // one table write per cycle: a new key letter or a fill step
  always_comb begin
    wr_en = 1'b0;
    wr_letter = in_idx;
    if (state == StFill) begin
      wr_letter = fill_idx;
      wr_en = !letters_used[fill_idx];
    end else if (accept && opcode == OpAddKey && in_letter) begin
      wr_en = !letters_used[in_idx];
    end
  end

  always_comb begin
    res_char = 8'd0;
    res_err = 1'b0;
    res_use_mem = 1'b0;
    case (opcode)
      OpAddKey: begin
        res_err = !in_letter;
      end
      OpEncrypt, OpDecrypt: begin
        if (!key_ready) begin
          res_char = in_char;
          res_err = 1'b1;
        end else if (!in_letter) begin
          res_char = in_char;
        end else begin
          res_use_mem = 1'b1;
        end
      end
      default: begin
        res_char = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cipher_mem[key_length] <= wr_letter;
      inverse_mem[wr_letter] <= key_length;
    end
    if (accept) begin
      cipher_rd <= cipher_mem[in_idx];
      inverse_rd <= inverse_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      letters_used <= '0;
      key_length <= '0;
      key_ready <= 1'b0;
      fill_idx <= '0;
    end else begin
      if (wr_en) begin
        letters_used[wr_letter] <= 1'b1;
        key_length <= key_length + 1'b1;
      end
      if (state == StFill) begin
        if (fill_idx == IdxW'(NumLetters - 1)) begin
          state <= StIdle;
        end
        fill_idx <= fill_idx + 1'b1;
      end else if (accept) begin
        case (opcode)
          OpClear: begin
            letters_used <= '0;
            key_length <= '0;
            key_ready <= 1'b0;
          end
          OpFinish: begin
            state <= StFill;
            fill_idx <= '0;
            key_ready <= 1'b1;
          end
          default: begin
            key_ready <= key_ready;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_use_mem <= res_use_mem;
      s1_inv <= (opcode == OpDecrypt);
      s1_char <= res_char;
      s1_err <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      error <= s1_err;
      if (!s1_use_mem) begin
        out_char <= s1_char;
      end else if (s1_inv) begin
        out_char <= AsciiUpperA + {3'b000, inverse_rd};
      end else begin
        out_char <= AsciiUpperA + {3'b000, cipher_rd};
      end
    end
  end

  a_fill_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == StFill) |-> !in_ready)
    else $error("input taken during key fill");

  a_fill_completes_key: assert property (@(posedge clk) disable iff (rst)
    (state == StFill && fill_idx == IdxW'(NumLetters - 1)) |=>
      (letters_used == '1 && key_length == IdxW'(NumLetters)))
    else $error("key not full after fill");

  a_length_matches_mask: assert property (@(posedge clk) disable iff (rst)
    key_length == IdxW'($countones(letters_used)))
    else $error("key length and used mask disagree");

  a_out_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("read stage lost during output stall");

endmodule

FILE: dv/keyword_substitution_cipher_unit_tb.sv
// testbench for the keyword substitution cipher unit: directed and random words against a scoreboard
`timescale 1ns / 1ps

module keyword_substitution_cipher_unit_tb;
  import kscu_pkg::*;

  localparam logic [2:0] OpRsvdA = 3'd5;
  localparam logic [2:0] OpRsvdB = 3'd6;
  localparam logic [2:0] OpRsvdC = 3'd7;
  localparam int TotalWords = 925;
  localparam int WatchdogLimit = 2000;
  localparam int HoldOffCycles = 200;

  typedef struct packed {
    logic       err;
    logic [7:0] ch;
  } cipher_word_t;

  class cipher_scoreboard;
    letter_idx_t fwd_map [NumLetters] = '{default: '0};
    letter_idx_t rev_map [NumLetters] = '{default: '0};
    logic [NumLetters-1:0] used_mask = '0;
    logic [IdxW-1:0] key_len = '0;
    logic key_done = 1'b0;
    cipher_word_t expected_q[$];
    int n_fail = 0;
    int n_checked = 0;
    int n_keys = 0;
    int n_lookups = 0;

    function int letter_of(logic [7:0] ch);
      if (ch >= AsciiUpperA && ch <= AsciiUpperZ) return int'(ch - AsciiUpperA);
      if (ch >= AsciiLowerA && ch <= AsciiLowerZ) return int'(ch - AsciiLowerA);
      return -1;
    endfunction

    function void append(int idx);
      if (key_len < NumLetters) begin
        fwd_map[key_len] = letter_idx_t'(idx);
        key_len = key_len + 1'b1;
        used_mask[idx] = 1'b1;
      end
    endfunction

    function void note_input(logic [2:0] op, logic [7:0] ch);
      int li;
      cipher_word_t want;
      li = letter_of(ch);
      want = '0;
      case (op)
        OpClear: begin
          used_mask = '0;
          key_len = '0;
          key_done = 1'b0;
        end
        OpAddKey: begin
          if (li < 0) want.err = 1'b1;
          else if (!used_mask[li]) append(li);
        end
        OpFinish: begin
          for (int i = 0; i < NumLetters; i++) begin
            if (!used_mask[i]) append(i);
          end
          for (int i = 0; i < NumLetters; i++) rev_map[fwd_map[i]] = letter_idx_t'(i);
          key_done = 1'b1;
          n_keys++;
        end
        OpEncrypt, OpDecrypt: begin
          n_lookups++;
          if (!key_done) begin
            want.ch = ch;
            want.err = 1'b1;
          end else if (li < 0) begin
            want.ch = ch;
          end else if (op == OpEncrypt) begin
            want.ch = AsciiUpperA + 8'(fwd_map[li]);
          end else begin
            want.ch = AsciiUpperA + 8'(rev_map[li]);
          end
        end
        default: ;
      endcase
      expected_q.push_back(want);
    endfunction

    function void check_result(logic [7:0] got_ch, logic got_err);
      cipher_word_t want;
      n_checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected word: out_char=%h error=%b", got_ch, got_err);
        n_fail++;
        return;
      end
      want = expected_q.pop_front();
      if (got_ch !== want.ch) begin
        $error("out_char mismatch: expected %h, actual %h", want.ch, got_ch);
        n_fail++;
      end
      if (got_err !== want.err) begin
        $error("error mismatch: expected %b, actual %b", want.err, got_err);
        n_fail++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] opcode = OpClear;
  logic [7:0] in_char = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       error;

  cipher_scoreboard sb = new();
  int n_sent = 0;
  int n_results = 0;
  int quiet_cycles = 0;
  bit held_off = 1'b0;

  keyword_substitution_cipher_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .error     (error)
  );

  always #5 clk = ~clk;

  task automatic send_word(input logic [2:0] op, input logic [7:0] ch);
    bit took;
    while (!(n_sent >= 400 && n_sent < 550) && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    in_char <= ch;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sb.note_input(op, ch);
    n_sent++;
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 45) return AsciiUpperA + 8'($urandom_range(NumLetters - 1));
    if (r < 80) return AsciiLowerA + 8'($urandom_range(NumLetters - 1));
    if (r < 84) return AsciiUpperA - 8'd1;
    if (r < 87) return AsciiUpperZ + 8'd1;
    if (r < 90) return AsciiLowerA - 8'd1;
    if (r < 92) return AsciiLowerZ + 8'd1;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] key_char();
    if ($urandom_range(99) < 88) begin
      return ($urandom_range(1) ? AsciiUpperA : AsciiLowerA) + 8'($urandom_range(NumLetters - 1));
    end
    return 8'($urandom);
  endfunction

  task automatic key_and_text(input bit do_finish);
    logic [7:0] alphabet [NumLetters];
    logic [7:0] tmp;
    int j;
    send_word(OpClear, 8'($urandom));
    if ($urandom_range(9) == 0) begin
      // whole alphabet in shuffled order, finish appends nothing
      for (int i = 0; i < NumLetters; i++) alphabet[i] = AsciiUpperA + 8'(i);
      for (int i = NumLetters - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = alphabet[i];
        alphabet[i] = alphabet[j];
        alphabet[j] = tmp;
      end
      for (int i = 0; i < NumLetters; i++) send_word(OpAddKey, alphabet[i]);
    end else begin
      repeat ($urandom_range(99) < 90 ? $urandom_range(12) : $urandom_range(40)) begin
        send_word(OpAddKey, key_char());
      end
    end
    if (do_finish) send_word(OpFinish, 8'($urandom));
    repeat ($urandom_range(30, 4)) begin
      send_word($urandom_range(1) ? OpEncrypt : OpDecrypt, text_char());
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(6, 1)) send_word(3'($urandom), 8'($urandom));
  endtask

  // result monitor, sampled mid-cycle where every signal is settled
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_char, error);
      n_results++;
    end
  end

  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && n_results >= 100) begin
        // long stall so the block fills up and drops in_ready
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      if (n_results >= 250 && n_results < 400) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(99) >= 34);
      @(posedge clk);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < WatchdogLimit) begin
      @(negedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("no word moved for %0d cycles", WatchdogLimit);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_word(OpEncrypt, "A");
    send_word(OpDecrypt, 8'hff);
    send_word(OpAddKey, 8'h00);
    send_word(OpAddKey, 8'hff);
    send_word(OpAddKey, "K");
    send_word(OpAddKey, "e");
    send_word(OpAddKey, "y");
    send_word(OpAddKey, "k");
    send_word(OpAddKey, "Z");
    send_word(OpFinish, 8'h00);
    send_word(OpEncrypt, "A");
    send_word(OpEncrypt, "z");
    send_word(OpEncrypt, AsciiUpperA - 8'd1);
    send_word(OpDecrypt, "K");
    send_word(OpDecrypt, "a");
    send_word(OpDecrypt, AsciiUpperZ + 8'd1);
    send_word(OpAddKey, "Q");
    send_word(OpAddKey, AsciiLowerZ + 8'd1);
    send_word(OpFinish, 8'hff);
    send_word(OpEncrypt, "y");
    send_word(OpRsvdA, 8'hff);
    send_word(OpRsvdB, 8'h00);
    send_word(OpRsvdC, "A");
    send_word(OpClear, 8'h00);
    send_word(OpEncrypt, "B");

    while (n_sent < TotalWords) begin
      r = $urandom_range(99);
      if (r < 80) key_and_text(1'b1);
      else if (r < 90) key_and_text(1'b0);
      else noise_burst();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("drove %0d words, checked %0d results, %0d mismatches", n_sent, sb.n_checked,
             sb.n_fail);
    $display("built %0d keys and ran %0d lookups, with a %0d-cycle output stall", sb.n_keys,
             sb.n_lookups, HoldOffCycles);
    if (sb.n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/kscu_pkg.sv
src/keyword_substitution_cipher_unit.sv
dv/keyword_substitution_cipher_unit_tb.sv
